>>> sv/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants for the raster blit combine core: register
// map, mode codes, configuration and position structs.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // register file geometry
  localparam int unsigned NUM_REGS   = 6;
  localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
  localparam int unsigned ADDR_W     = REG_IDX_W + 2;
  localparam int unsigned DATA_W     = 32;

  // field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned PIX_W      = 6;
  localparam int unsigned BPL_W      = 14;
  localparam int unsigned LCNT_W     = 16;
  localparam int unsigned WADDR_W    = 32;
  localparam int unsigned PITCH_W    = 14;
  localparam int unsigned BYTE_W     = 8;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE       = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_BITS = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_BPL        = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_DST_BASE   = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_DST_PITCH  = REG_IDX_W'(5);

  // combine modes
  localparam logic [MODE_W-1:0] MODE_COPY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL  = 2'd2;

  // add and multiply only work on byte pixels
  localparam logic [PIX_W-1:0] NEEDED_PIXEL_BITS = PIX_W'(8);
  localparam int unsigned      MUL_SHIFT         = 7;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PIX_W-1:0]   pixel_bits;
    logic [BPL_W-1:0]   bytes_per_line;
    logic [LCNT_W-1:0]  line_count;
    logic [WADDR_W-1:0] dst_base;
    logic [PITCH_W-1:0] dst_pitch;
  } rbc_cfg_t;

  // position of the word being accepted
  typedef struct packed {
    logic [WADDR_W-1:0] addr;
    logic               last;
  } rbc_pos_t;

endpackage

>>> sv/rbc_regs.sv
// ----------------------------------------------------------------------------
// rbc_regs
// APB-style configuration register file; writes complete in the access
// phase, reads return the zero-extended register value.
// ----------------------------------------------------------------------------
module rbc_regs
  import rbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output rbc_cfg_t          cfg
);

  rbc_cfg_t               cfg_r;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_COPY;
      cfg_r.pixel_bits     <= NEEDED_PIXEL_BITS;
      cfg_r.bytes_per_line <= BPL_W'(1);
      cfg_r.line_count     <= LCNT_W'(1);
      cfg_r.dst_base       <= '0;
      cfg_r.dst_pitch      <= PITCH_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:       cfg_r.mode           <= pwdata[MODE_W-1:0];
        REG_PIXEL_BITS: cfg_r.pixel_bits     <= pwdata[PIX_W-1:0];
        REG_BPL:        cfg_r.bytes_per_line <= pwdata[BPL_W-1:0];
        REG_LINE_COUNT: cfg_r.line_count     <= pwdata[LCNT_W-1:0];
        REG_DST_BASE:   cfg_r.dst_base       <= pwdata[WADDR_W-1:0];
        REG_DST_PITCH:  cfg_r.dst_pitch      <= pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_MODE:       prdata = DATA_W'(cfg_r.mode);
      REG_PIXEL_BITS: prdata = DATA_W'(cfg_r.pixel_bits);
      REG_BPL:        prdata = DATA_W'(cfg_r.bytes_per_line);
      REG_LINE_COUNT: prdata = DATA_W'(cfg_r.line_count);
      REG_DST_BASE:   prdata = DATA_W'(cfg_r.dst_base);
      REG_DST_PITCH:  prdata = DATA_W'(cfg_r.dst_pitch);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> sv/rbc_addr_gen.sv
// ----------------------------------------------------------------------------
// rbc_addr_gen
// Raster walker: column, row and line-start counters that give the
// destination address and end-of-rectangle flag of each accepted word.
// ----------------------------------------------------------------------------
module rbc_addr_gen
  import rbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  rbc_cfg_t cfg,
  output rbc_pos_t pos
);

  logic [BPL_W-1:0]   col_r,  col_nxt;
  logic [LCNT_W-1:0]  row_r,  row_nxt;
  logic [WADDR_W-1:0] lstart_r, lstart_nxt;
  logic [WADDR_W-1:0] lstart_cur;
  logic               end_line;
  logic               end_rect;

  // first word of a rectangle reloads the line start from the base
  assign lstart_cur = (col_r == '0 && row_r == '0) ? cfg.dst_base : lstart_r;

  // limits of 0 behave as 1 through the >= compare
  assign end_line = ({1'b0, col_r} + (BPL_W+1)'(1)) >= {1'b0, cfg.bytes_per_line};
  assign end_rect = end_line &&
                    (({1'b0, row_r} + (LCNT_W+1)'(1)) >= {1'b0, cfg.line_count});

  assign pos.addr = lstart_cur + WADDR_W'(col_r);
  assign pos.last = end_rect;

  // counter update
  always_comb begin
    col_nxt    = col_r + BPL_W'(1);
    row_nxt    = row_r;
    lstart_nxt = lstart_cur;
    if (end_rect) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (end_line) begin
      col_nxt    = '0;
      row_nxt    = row_r + LCNT_W'(1);
      lstart_nxt = lstart_cur + WADDR_W'(cfg.dst_pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      lstart_r <= '0;
    end else if (advance) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lstart_r <= lstart_nxt;
    end
  end

endmodule

>>> sv/raster_blit_combine_core.sv
// Pipeline: two registers (input, then result); out_valid rises once the word moves
// from the input register into the result register, which out_stall can hold up.
// Throughput: one word per cycle while out_stall is low; while a result waits, the
// input register still takes a word if it is empty, and in_stall then rises.
// Reset (rst_n low, synchronous): pipeline emptied, raster counters zeroed,
// registers back to copy mode, 8-bit pixels, 1x1 rectangle, base 0, pitch 1.
// ----------------------------------------------------------------------------
// raster_blit_combine_core
// Rectangle blit combiner: combines source and destination bytes by copy,
// wrapping add or multiply-shift, tags each with its write address, flags errors.
// ----------------------------------------------------------------------------
module raster_blit_combine_core
  import rbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_src_byte,
  input  logic [BYTE_W-1:0]  in_dst_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_enable,
  output logic [WADDR_W-1:0] out_write_address,
  output logic [BYTE_W-1:0]  out_result_byte,
  output logic               out_last,
  output logic               out_error
);

  rbc_cfg_t cfg;
  rbc_pos_t pos;

  logic                   in_acc;
  logic                   s1_adv;
  logic                   s2_adv;

  // input register
  logic                   s1_valid_r;
  logic [BYTE_W-1:0]      s1_src_r;
  logic [BYTE_W-1:0]      s1_dst_r;
  logic [WADDR_W-1:0]     s1_addr_r;
  logic                   s1_last_r;

  // result register
  logic                   s2_valid_r;
  logic                   s2_we_r,   s2_we_nxt;
  logic [WADDR_W-1:0]     s2_addr_r;
  logic [BYTE_W-1:0]      s2_res_r,  s2_res_nxt;
  logic                   s2_last_r;
  logic                   s2_err_r,  s2_err_nxt;

  logic [2*BYTE_W-1:0]    product;
  logic                   pix_ok;

  rbc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbc_addr_gen u_addr_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .cfg     (cfg),
    .pos     (pos)
  );

  // pipeline flow control
  assign s2_adv   = s1_valid_r && (!s2_valid_r || !out_stall);
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // input register: bytes plus position taken at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r  <= in_src_byte;
      s1_dst_r  <= in_dst_byte;
      s1_addr_r <= pos.addr;
      s1_last_r <= pos.last;
    end
  end

  // combine by mode
  assign product = s1_src_r * s1_dst_r;
  assign pix_ok  = (cfg.pixel_bits == NEEDED_PIXEL_BITS);

  always_comb begin
    s2_we_nxt  = 1'b0;
    s2_res_nxt = '0;
    s2_err_nxt = 1'b0;
    case (cfg.mode)
      MODE_COPY: begin
        s2_we_nxt  = 1'b1;
        s2_res_nxt = s1_src_r;
      end
      MODE_ADD: begin
        if (pix_ok) begin
          s2_we_nxt  = 1'b1;
          s2_res_nxt = s1_src_r + s1_dst_r;
        end else begin
          s2_err_nxt = 1'b1;
        end
      end
      MODE_MUL: begin
        if (pix_ok) begin
          s2_we_nxt  = 1'b1;
          s2_res_nxt = product[MUL_SHIFT +: BYTE_W];
        end else begin
          s2_err_nxt = 1'b1;
        end
      end
      default: begin
        s2_err_nxt = 1'b1;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b1;
    end else if (!out_stall) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_we_r   <= s2_we_nxt;
      s2_addr_r <= s1_addr_r;
      s2_res_r  <= s2_res_nxt;
      s2_last_r <= s1_last_r;
      s2_err_r  <= s2_err_nxt;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_write_enable  = s2_we_r;
  assign out_write_address = s2_addr_r;
  assign out_result_byte   = s2_res_r;
  assign out_last          = s2_last_r;
  assign out_error         = s2_err_r;

`ifndef ASSERT_OFF
  // a word is never both written and flagged as an error
  a_we_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_write_enable && out_error))
    else $error("write and error both set");

  // suppressed writes carry a zero byte
  a_no_we_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_result_byte == '0))
    else $error("nonzero byte without write");

  // a full pipeline that cannot drain must push back on the input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && out_stall) |-> in_stall)
    else $error("input taken while pipeline blocked");

  // an output held under stall is not overwritten by the next word
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && out_stall) |=> (s2_valid_r && $stable(s2_addr_r)))
    else $error("stalled result overwritten");
`endif

endmodule
